### rtl/core/nras_pkg.sv
// Shared types and constants for the noisy ring automaton step block.
// Used by nras_ctrl, nras_dp and noisy_ring_automaton_step_top; no dependencies.
package nras_pkg;

  localparam int unsigned CELLS  = 512;
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 3);
  localparam int unsigned CELL_W = 5;
  localparam int unsigned POP_W  = 10;

  localparam logic [POP_W-1:0] POP_MAX = {POP_W{1'b1}};

  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [31:0] SEED_RST   = 32'd1;
  localparam logic [15:0] NOISE_RST  = 16'd1966;
  localparam logic [15:0] FORGET_RST = 16'd3277;

  // Item modes.
  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NOISE  = 2'd0;
  localparam logic [1:0] CFG_FORGET = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  typedef enum logic [1:0] {
    PASS_NOISE  = 2'd0,
    PASS_EMIT   = 2'd1,
    PASS_SHIFT  = 2'd2,
    PASS_EFFECT = 2'd3
  } pass_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] cell_index;
    logic [4:0] cell_data;
  } in_item_t;

  typedef struct packed {
    logic [9:0] population;
    logic [4:0] cell_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             win_en;
    logic [IDX_W-1:0] win_idx;
    pass_e            pass;
    logic             item_rd;
    logic             single_step;
    logic             load_out;
  } cmd_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

### rtl/core/nras_ctrl.sv
// Controller for the noisy ring automaton step block: clearing sweep,
// pass sequencing and handshakes. Depends on nras_pkg.
module nras_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nras_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nras_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PASS  = 6'b000100,
    ST_SREAD = 6'b001000,
    ST_SDONE = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [nras_pkg::CNT_W-1:0] cnt_q, cnt_d;
  nras_pkg::pass_e            pass_q, pass_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_range;

  assign in_range = 32'(in_data_i.cell_index) < 32'(nras_pkg::CELLS);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    cmd_o             = '0;
    cmd_o.pass        = pass_q;
    cmd_o.clr_addr    = nras_pkg::IDX_W'(cnt_q);
    cmd_o.win_idx     = nras_pkg::IDX_W'(cnt_q - nras_pkg::CNT_W'(2));
    cmd_o.rd_addr     = nras_pkg::IDX_W'(cnt_q - nras_pkg::CNT_W'(1));

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (cnt_q == nras_pkg::CNT_W'(nras_pkg::CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + nras_pkg::CNT_W'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_data_i.mode == nras_pkg::MODE_RUN) begin
            state_d = ST_PASS;
            pass_d  = nras_pkg::PASS_NOISE;
            cnt_d   = '0;
          end else if ((in_data_i.mode == nras_pkg::MODE_WRITE ||
                        in_data_i.mode == nras_pkg::MODE_READ) && in_range) begin
            state_d = ST_SREAD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_PASS: begin
        // Reads go left wrap cell, then every cell, then cell 0 again so that
        // each cell sees both neighbors.
        cmd_o.rd_en  = cnt_q <= nras_pkg::CNT_W'(nras_pkg::CELLS + 1);
        cmd_o.win_en = cnt_q >= nras_pkg::CNT_W'(2) &&
                       cnt_q <= nras_pkg::CNT_W'(nras_pkg::CELLS + 1);
        if (cnt_q == '0) begin
          cmd_o.rd_addr = nras_pkg::IDX_W'(nras_pkg::CELLS - 1);
        end else if (cnt_q == nras_pkg::CNT_W'(nras_pkg::CELLS + 1)) begin
          cmd_o.rd_addr = '0;
        end
        if (cnt_q == nras_pkg::CNT_W'(nras_pkg::CELLS + 2)) begin
          cnt_d = '0;
          if (pass_q == nras_pkg::PASS_EFFECT) begin
            state_d = ST_RESP;
          end else begin
            pass_d = nras_pkg::pass_e'(pass_q + 2'd1);
          end
        end else begin
          cnt_d = cnt_q + nras_pkg::CNT_W'(1);
        end
      end
      ST_SREAD: begin
        cmd_o.item_rd = 1'b1;
        state_d       = ST_SDONE;
      end
      ST_SDONE: begin
        cmd_o.single_step = 1'b1;
        state_d           = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pass_q      <= nras_pkg::PASS_NOISE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PASS |-> cnt_q <= nras_pkg::CNT_W'(nras_pkg::CELLS + 2))
    else $error("pass counter overran");
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.mode == nras_pkg::MODE_RUN)
      |=> (state_q == ST_PASS && cnt_q == '0))
    else $error("run item did not start the noise pass");
  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

### rtl/core/nras_dp.sv
// Datapath for the noisy ring automaton step block: cell and scratch memories,
// neighbor window, random generator, population count and output register.
// Depends on nras_pkg.
module nras_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  nras_pkg::in_item_t  in_data_i,
  input  nras_pkg::cmd_t      cmd_i,
  output nras_pkg::out_item_t out_data_o
);

  logic [nras_pkg::CELL_W-1:0] cells_mem   [nras_pkg::CELLS];
  logic [nras_pkg::CELL_W-1:0] scratch_mem [nras_pkg::CELLS];
  logic [nras_pkg::CELL_W-1:0] cells_rd_q, scratch_rd_q, rdata;

  logic [15:0]                 noise_th_q, forget_th_q;
  logic [31:0]                 lfsr_q, lfsr_d, draw1, draw2;
  logic [nras_pkg::POP_W-1:0]  count_q, count_d, acc_q, acc_d, acc_base;
  nras_pkg::in_item_t          item_q;
  logic [nras_pkg::CELL_W-1:0] value_q;
  nras_pkg::out_item_t         out_q;

  logic                        rd_cells_q, rdv_q;
  logic                        st_en_q;
  logic [nras_pkg::IDX_W-1:0]  st_idx_q;
  nras_pkg::pass_e             st_pass_q;
  logic [nras_pkg::CELL_W-1:0] w_prev_q, w_cur_q;

  logic [nras_pkg::CELL_W-1:0] p, c, n, val;
  logic [nras_pkg::IDX_W-1:0]  item_addr, rd_addr;
  logic                        r1, r3, rr2, rr4, own_en, right_en, new_main, last_cell;

  assign item_addr = nras_pkg::IDX_W'(item_q.cell_index);
  assign rd_addr   = cmd_i.item_rd ? item_addr : cmd_i.rd_addr;
  assign rdata     = rd_cells_q ? cells_rd_q : scratch_rd_q;
  assign p = w_prev_q;
  assign c = w_cur_q;
  assign n = rdata;

  assign draw1 = nras_pkg::lfsr_step(lfsr_q);
  assign draw2 = nras_pkg::lfsr_step(draw1);

  // Effect rules: own rule uses this cell and its left neighbor, the right
  // neighbor's rule may rewrite this cell's main bit as its left cell.
  assign r1  = !c[0] && p[0] && c[1];
  assign r3  =  c[0] && !p[0] && c[2];
  assign rr2 = !n[0] && c[0] && !n[1] && n[3];
  assign rr4 =  n[0] && !c[0] && !n[2] && n[4];
  assign own_en    = r1 || r3;
  assign right_en  = rr2 || rr4;
  assign last_cell = st_idx_q == nras_pkg::IDX_W'(nras_pkg::CELLS - 1);

  always_comb begin
    new_main = c[0];
    // The right neighbor's write comes later in index order, except for the
    // last cell, whose right neighbor is cell 0.
    if (last_cell) begin
      if (own_en) begin
        new_main = r1;
      end else if (right_en) begin
        new_main = rr4;
      end
    end else begin
      if (right_en) begin
        new_main = rr4;
      end else if (own_en) begin
        new_main = r1;
      end
    end
  end

  assign acc_base = (st_idx_q == '0) ? '0 : acc_q;

  always_comb begin
    val     = c;
    lfsr_d  = lfsr_q;
    acc_d   = acc_q;
    count_d = count_q;
    if (st_en_q) begin
      unique case (st_pass_q)
        nras_pkg::PASS_NOISE: begin
          lfsr_d = draw1;
          if (draw1[15:0] < noise_th_q) begin
            lfsr_d = draw2;
            val    = draw2[nras_pkg::CELL_W-1:0];
          end
        end
        nras_pkg::PASS_EMIT: begin
          if (c[0] && !p[0]) begin
            val = c | 5'b01010;
          end else if (!c[0] && p[0]) begin
            val = c | 5'b10100;
          end
        end
        nras_pkg::PASS_SHIFT: begin
          val = {p[4:3], n[2:1], c[0]};
        end
        nras_pkg::PASS_EFFECT: begin
          lfsr_d = draw1;
          val    = {c[4:1], new_main};
          if (draw1[15:0] < forget_th_q) begin
            val = {4'b0000, new_main};
          end
          acc_d = acc_base;
          if (new_main && acc_base != nras_pkg::POP_MAX) begin
            acc_d = acc_base + nras_pkg::POP_W'(1);
          end
          if (last_cell) begin
            count_d = acc_d;
          end
        end
        default: begin
          val = c;
        end
      endcase
    end
    if (cmd_i.single_step && item_q.mode == nras_pkg::MODE_WRITE) begin
      if (item_q.cell_data[0] && !rdata[0] && count_q != nras_pkg::POP_MAX) begin
        count_d = count_q + nras_pkg::POP_W'(1);
      end else if (!item_q.cell_data[0] && rdata[0] && count_q != '0) begin
        count_d = count_q - nras_pkg::POP_W'(1);
      end
    end
    if (cfg_we_i && cfg_index_i == nras_pkg::CFG_SEED) begin
      lfsr_d = (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
    end
  end

  // Memories: one read and one write port each, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en || cmd_i.item_rd) begin
      cells_rd_q   <= cells_mem[rd_addr];
      scratch_rd_q <= scratch_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      cells_mem[cmd_i.clr_addr] <= '0;
    end else if (st_en_q && (st_pass_q == nras_pkg::PASS_EMIT ||
                             st_pass_q == nras_pkg::PASS_EFFECT)) begin
      cells_mem[st_idx_q] <= val;
    end else if (cmd_i.single_step && item_q.mode == nras_pkg::MODE_WRITE) begin
      cells_mem[item_addr] <= item_q.cell_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_en_q && (st_pass_q == nras_pkg::PASS_NOISE ||
                    st_pass_q == nras_pkg::PASS_SHIFT)) begin
      scratch_mem[st_idx_q] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      w_cur_q  <= rdata;
      w_prev_q <= w_cur_q;
    end
    if (cmd_i.rd_en || cmd_i.item_rd) begin
      rd_cells_q <= cmd_i.item_rd || cmd_i.pass == nras_pkg::PASS_NOISE ||
                    cmd_i.pass == nras_pkg::PASS_SHIFT;
    end
    st_idx_q  <= cmd_i.win_idx;
    st_pass_q <= cmd_i.pass;
    acc_q     <= acc_d;
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q.population <= count_q;
      out_q.cell_value <= value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_th_q  <= nras_pkg::NOISE_RST;
      forget_th_q <= nras_pkg::FORGET_RST;
      lfsr_q      <= nras_pkg::SEED_RST;
      count_q     <= '0;
      value_q     <= '0;
      rdv_q       <= 1'b0;
      st_en_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == nras_pkg::CFG_NOISE) begin
        noise_th_q <= cfg_data_i[15:0];
      end
      if (cfg_we_i && cfg_index_i == nras_pkg::CFG_FORGET) begin
        forget_th_q <= cfg_data_i[15:0];
      end
      lfsr_q  <= lfsr_d;
      count_q <= count_d;
      rdv_q   <= cmd_i.rd_en;
      st_en_q <= cmd_i.win_en;
      if (cmd_i.accept) begin
        value_q <= '0;
      end else if (cmd_i.single_step && item_q.mode == nras_pkg::MODE_READ) begin
        value_q <= rdata;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/noisy_ring_automaton_step_top.sv
// Top level of the noisy ring automaton step block.
// Instantiates nras_ctrl and nras_dp; depends on nras_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i (mode, cell_index, cell_data)
//   out      output     out_valid_o / out_ready_i out_data_o (population, cell_value)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A run item takes four passes over the ring, which read the cell and scratch
// memories in turn (one cell per cycle through a single read port). A write or
// read item passes a read and a step state; an unused mode or out-of-ring index
// goes straight to the result. After reset a clearing sweep zeroes the ring; no
// item is taken then. One item is in work at a time; a stalled result holds in the
// output register while the next item is accepted.
module noisy_ring_automaton_step_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nras_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nras_pkg::out_item_t out_data_o
);

  nras_pkg::cmd_t cmd;

  nras_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  nras_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule
